// ===== rtl/packet_magic_crc32_validator_unit_defines.svh =====
// Assertion macros used by the validator top file.
`ifndef PACKET_MAGIC_CRC32_VALIDATOR_UNIT_DEFINES_SVH
`define PACKET_MAGIC_CRC32_VALIDATOR_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PMCV_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("pmcv: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define PMCV_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("pmcv: next-cycle check failed");

`endif

// ===== rtl/pmcv_pkg.sv =====
package pmcv_pkg;

	// Verdict codes of one packet.
	typedef enum logic [2:0] {
		V_FWD   = 3'd0,
		V_RADIO = 3'd1,
		V_MAGIC = 3'd2,
		V_CRC   = 3'd3,
		V_LONG  = 3'd4
	} verdict_t;

	// Configuration register indexes.
	localparam logic [1:0] CFG_MAGIC = 2'd0;
	localparam logic [1:0] CFG_MIN   = 2'd1;
	localparam logic [1:0] CFG_SMALL = 2'd2;

	localparam logic [31:0] MAGIC_RESET = 32'h5241_5054;
	localparam logic [7:0]  MIN_RESET   = 8'd12;
	localparam logic [8:0]  SMALL_RESET = 9'd100;

	localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
	localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

	// Counter slots.
	localparam int NUM_CNT   = 7;
	localparam int CNT_TOTAL = 0;
	localparam int CNT_FWD   = 1;
	localparam int CNT_MAGIC = 2;
	localparam int CNT_CRC   = 3;
	localparam int CNT_RADIO = 4;
	localparam int CNT_SMALL = 5;
	localparam int CNT_LARGE = 6;

	// Classified packet handed from the front to the back.
	typedef struct packed {
		verdict_t    verdict;
		logic [8:0]  length;
		logic        is_small;
	} rec_t;

	// Reflected CRC-32 update over one byte, one bit per step.
	function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
		logic [31:0] x;
		x = c ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			x = (x >> 1) ^ (CRC_POLY & {32{x[0]}});
		end
		return x;
	endfunction

endpackage

// ===== rtl/pmcv_front.sv =====
module pmcv_front #(
	parameter int MAX_PACKET_BYTES = 255
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_write,
	input  logic [1:0]       cfg_index,
	input  logic [31:0]      cfg_data,
	input  logic             accept,
	input  logic [7:0]       data_byte,
	input  logic             last_byte,
	input  logic             radio_error,
	output logic             rec_valid,
	output pmcv_pkg::rec_t   rec
);

	localparam int CW = $clog2(MAX_PACKET_BYTES + 2);
	localparam int LW = (CW > 10) ? CW : 10;

	logic [31:0]   magic_q;
	logic [7:0]    min_q;
	logic [8:0]    small_q;
	logic [31:0]   crc_q;
	logic [7:0]    td_q [4];
	logic [CW-1:0] count_q;
	logic          magic_ok_q;

	logic [31:0]   crc_n;
	logic [CW-1:0] count_n;
	logic          magic_ok_n;
	logic [7:0]    want;
	logic          head;
	logic [LW-1:0] len_ext;
	logic [31:0]   trailer;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			magic_q <= pmcv_pkg::MAGIC_RESET;
			min_q   <= pmcv_pkg::MIN_RESET;
			small_q <= pmcv_pkg::SMALL_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				pmcv_pkg::CFG_MAGIC: magic_q <= cfg_data;
				pmcv_pkg::CFG_MIN:   min_q   <= cfg_data[7:0];
				pmcv_pkg::CFG_SMALL: small_q <= cfg_data[8:0];
				default: ;
			endcase
		end
	end

	// The first four bytes are compared against the magic, big-endian.
	always_comb begin
		case (count_q[1:0])
			2'd0:    want = magic_q[31:24];
			2'd1:    want = magic_q[23:16];
			2'd2:    want = magic_q[15:8];
			default: want = magic_q[7:0];
		endcase
	end

	assign head = (count_q < CW'(4));

	// Per-byte state update: the CRC runs four bytes behind the input.
	always_comb begin
		magic_ok_n = magic_ok_q;
		crc_n      = crc_q;
		if (head) begin
			magic_ok_n = magic_ok_q & (data_byte == want);
		end else begin
			crc_n = pmcv_pkg::crc_byte(crc_q, td_q[0]);
		end
		if (count_q <= CW'(MAX_PACKET_BYTES)) begin
			count_n = count_q + CW'(1);
		end else begin
			count_n = count_q;
		end
	end

	assign len_ext = LW'(count_n);
	assign trailer = {td_q[1], td_q[2], td_q[3], data_byte};

	// Classify the packet on its last byte.
	always_comb begin
		rec_valid = accept & last_byte;
		if (len_ext > LW'(MAX_PACKET_BYTES)) begin
			rec.verdict = pmcv_pkg::V_LONG;
		end else if (radio_error) begin
			rec.verdict = pmcv_pkg::V_RADIO;
		end else if ((len_ext < LW'(min_q)) || (len_ext < LW'(4)) || !magic_ok_n) begin
			rec.verdict = pmcv_pkg::V_MAGIC;
		end else if (trailer != ~crc_n) begin
			rec.verdict = pmcv_pkg::V_CRC;
		end else begin
			rec.verdict = pmcv_pkg::V_FWD;
		end
		if (len_ext > LW'(256)) begin
			rec.length = 9'd256;
		end else begin
			rec.length = len_ext[8:0];
		end
		rec.is_small = (len_ext < LW'(small_q));
	end

	// Packet state, cleared after every last byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q      <= pmcv_pkg::CRC_INIT;
			count_q    <= '0;
			magic_ok_q <= 1'b1;
		end else if (accept) begin
			if (last_byte) begin
				crc_q      <= pmcv_pkg::CRC_INIT;
				count_q    <= '0;
				magic_ok_q <= 1'b1;
			end else begin
				crc_q      <= crc_n;
				count_q    <= count_n;
				magic_ok_q <= magic_ok_n;
			end
		end
	end

	// Trailer delay line.
	always_ff @(posedge clk) begin
		if (accept) begin
			td_q[0] <= td_q[1];
			td_q[1] <= td_q[2];
			td_q[2] <= td_q[3];
			td_q[3] <= data_byte;
		end
	end

endmodule

// ===== rtl/pmcv_queue.sv =====
module pmcv_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr,
	input  pmcv_pkg::rec_t   wr_data,
	input  logic             rd,
	output pmcv_pkg::rec_t   rd_data,
	output logic             full,
	output logic             empty
);

	localparam int DEPTH = 2;
	localparam int AW    = $clog2(DEPTH);

	pmcv_pkg::rec_t mem_q [DEPTH];
	logic [AW-1:0]  wp_q;
	logic [AW-1:0]  rp_q;
	logic [AW:0]    cnt_q;

	assign full    = (cnt_q == (AW + 1)'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign rd_data = mem_q[rp_q];

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) begin
				wp_q <= (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + AW'(1);
			end
			if (rd) begin
				rp_q <= (rp_q == AW'(DEPTH - 1)) ? '0 : rp_q + AW'(1);
			end
			if (wr && !rd) begin
				cnt_q <= cnt_q + (AW + 1)'(1);
			end else if (rd && !wr) begin
				cnt_q <= cnt_q - (AW + 1)'(1);
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wp_q] <= wr_data;
		end
	end

endmodule

// ===== rtl/pmcv_back.sv =====
module pmcv_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_empty,
	input  pmcv_pkg::rec_t   q_data,
	output logic             q_rd,
	input  logic             pop,
	output logic             empty,
	output logic [2:0]       verdict,
	output logic [8:0]       packet_length,
	output logic [31:0]      total_count,
	output logic [31:0]      forwarded_count,
	output logic [31:0]      magic_reject_count,
	output logic [31:0]      crc_reject_count,
	output logic [31:0]      radio_error_count,
	output logic [31:0]      small_count,
	output logic [31:0]      large_count
);

	logic             out_valid_q;
	pmcv_pkg::rec_t   out_q;
	logic [31:0]      cnt_q [pmcv_pkg::NUM_CNT];
	logic [pmcv_pkg::NUM_CNT-1:0] inc;

	// Take the next packet whenever the output register is free or draining.
	assign q_rd  = !q_empty && (!out_valid_q || pop);
	assign empty = !out_valid_q;

	// Which counters this packet bumps.
	always_comb begin
		inc = '0;
		case (q_data.verdict)
			pmcv_pkg::V_FWD: begin
				inc[pmcv_pkg::CNT_TOTAL] = 1'b1;
				inc[pmcv_pkg::CNT_FWD]   = 1'b1;
				inc[pmcv_pkg::CNT_SMALL] = q_data.is_small;
				inc[pmcv_pkg::CNT_LARGE] = !q_data.is_small;
			end
			pmcv_pkg::V_RADIO: begin
				inc[pmcv_pkg::CNT_TOTAL] = 1'b1;
				inc[pmcv_pkg::CNT_RADIO] = 1'b1;
			end
			pmcv_pkg::V_MAGIC: begin
				inc[pmcv_pkg::CNT_TOTAL] = 1'b1;
				inc[pmcv_pkg::CNT_MAGIC] = 1'b1;
			end
			pmcv_pkg::V_CRC: begin
				inc[pmcv_pkg::CNT_TOTAL] = 1'b1;
				inc[pmcv_pkg::CNT_CRC]   = 1'b1;
			end
			default: inc = '0;
		endcase
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (q_rd) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output payload.
	always_ff @(posedge clk) begin
		if (q_rd) begin
			out_q <= q_data;
		end
	end

	// Wrapping packet counters; they change only when a new beat loads.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < pmcv_pkg::NUM_CNT; i++) begin
				cnt_q[i] <= '0;
			end
		end else if (q_rd) begin
			for (int i = 0; i < pmcv_pkg::NUM_CNT; i++) begin
				cnt_q[i] <= cnt_q[i] + {31'd0, inc[i]};
			end
		end
	end

	assign verdict            = out_q.verdict;
	assign packet_length      = out_q.length;
	assign total_count        = cnt_q[pmcv_pkg::CNT_TOTAL];
	assign forwarded_count    = cnt_q[pmcv_pkg::CNT_FWD];
	assign magic_reject_count = cnt_q[pmcv_pkg::CNT_MAGIC];
	assign crc_reject_count   = cnt_q[pmcv_pkg::CNT_CRC];
	assign radio_error_count  = cnt_q[pmcv_pkg::CNT_RADIO];
	assign small_count        = cnt_q[pmcv_pkg::CNT_SMALL];
	assign large_count        = cnt_q[pmcv_pkg::CNT_LARGE];

endmodule

// ===== rtl/packet_magic_crc32_validator_unit.sv =====
// Takes one packet byte per cycle while full is low; full rises only while the two-entry
// verdict queue is full. An accepted last byte's verdict reaches the result ports via the
// queue write, then the output register; results drain at one per cycle while pop is held.
// The byte-wide CRC step and trailer compare in the front form the combinational byte path.
// Reset clears counters, packet state and queues and loads the register defaults at once.
`include "packet_magic_crc32_validator_unit_defines.svh"

module packet_magic_crc32_validator_unit #(
	parameter int MAX_PACKET_BYTES = 255
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	input  logic        radio_error,
	output logic        empty,
	input  logic        pop,
	output logic [2:0]  verdict,
	output logic [8:0]  packet_length,
	output logic [31:0] total_count,
	output logic [31:0] forwarded_count,
	output logic [31:0] magic_reject_count,
	output logic [31:0] crc_reject_count,
	output logic [31:0] radio_error_count,
	output logic [31:0] small_count,
	output logic [31:0] large_count
);

	logic           accept;
	logic           rec_valid;
	pmcv_pkg::rec_t rec;
	pmcv_pkg::rec_t q_data;
	logic           q_rd;
	logic           q_empty;

	assign accept = push && !full;

	// Front: byte intake, magic and CRC check, classification.
	pmcv_front #(
		.MAX_PACKET_BYTES(MAX_PACKET_BYTES)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_write  (cfg_write),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.accept     (accept),
		.data_byte  (data_byte),
		.last_byte  (last_byte),
		.radio_error(radio_error),
		.rec_valid  (rec_valid),
		.rec        (rec)
	);

	// Verdict queue between front and back.
	pmcv_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (rec_valid),
		.wr_data(rec),
		.rd     (q_rd),
		.rd_data(q_data),
		.full   (full),
		.empty  (q_empty)
	);

	// Back: counters and result register.
	pmcv_back u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.q_empty           (q_empty),
		.q_data            (q_data),
		.q_rd              (q_rd),
		.pop               (pop),
		.empty             (empty),
		.verdict           (verdict),
		.packet_length     (packet_length),
		.total_count       (total_count),
		.forwarded_count   (forwarded_count),
		.magic_reject_count(magic_reject_count),
		.crc_reject_count  (crc_reject_count),
		.radio_error_count (radio_error_count),
		.small_count       (small_count),
		.large_count       (large_count)
	);

	// A finished packet always lands in the queue.
	`PMCV_ASSERT_NEXT(a_last_queued, clk, arst_n, accept && last_byte, !q_empty)

	// The back never reads an empty queue.
	`PMCV_ASSERT_IMPLY(a_no_underrun, clk, arst_n, q_rd, !q_empty)

	// Forwarded and CRC-rejected packets always carried a complete magic.
	`PMCV_ASSERT_IMPLY(a_len_checked, clk, arst_n,
		!empty && (verdict == pmcv_pkg::V_FWD || verdict == pmcv_pkg::V_CRC),
		packet_length >= 9'd4)

endmodule

// ===== test/packet_verdict_checker.sv =====
`timescale 1ns / 1ps

module packet_verdict_checker #(
	parameter int MAX_BYTES = 255
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        push,
	input  logic        full,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	input  logic        radio_error,
	input  logic        empty,
	input  logic        pop,
	input  logic [2:0]  verdict,
	input  logic [8:0]  packet_length,
	input  logic [31:0] total_count,
	input  logic [31:0] forwarded_count,
	input  logic [31:0] magic_reject_count,
	input  logic [31:0] crc_reject_count,
	input  logic [31:0] radio_error_count,
	input  logic [31:0] small_count,
	input  logic [31:0] large_count,
	output int          mismatches,
	output int          waiting
);
	import pmcv_pkg::*;

	localparam logic [31:0] IEEE_REFLECTED = 32'hEDB8_8320;

	// One expected verdict beat with the counter snapshot after its packet.
	typedef struct packed {
		verdict_t                  code;
		logic [8:0]                len;
		logic [NUM_CNT-1:0][31:0]  cnt;
	} verdict_rec_t;

	string slot_name [NUM_CNT] = '{"total_count", "forwarded_count", "magic_reject_count",
		"crc_reject_count", "radio_error_count", "small_count", "large_count"};

	// Shadow copy of the registers and of the packet state.
	logic [31:0]              magic_reg;
	logic [7:0]               min_reg;
	logic [8:0]               size_split;
	logic [31:0]              crc_acc;
	logic [7:0]               tail [0:3];
	int                       seen;
	bit                       magic_good;
	logic [NUM_CNT-1:0][31:0] tally;
	verdict_rec_t             pending_verdicts [$];
	int                       fails = 0;
	int                       depth = 0;

	assign mismatches = fails;
	assign waiting = depth;

	// Bit-serial reflected CRC-32: each data bit enters at the low end.
	function automatic logic [31:0] crc_fold(input logic [31:0] acc, input logic [7:0] b);
		logic [31:0] r;
		logic        fb;
		r = acc;
		for (int i = 0; i < 8; i++) begin
			fb = r[0] ^ b[i];
			r = {1'b0, r[31:1]};
			if (fb) begin
				r = r ^ IEEE_REFLECTED;
			end
		end
		return r;
	endfunction

	function automatic int field_diff(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (got !== want) begin
			$display("%0t %s expected %0h actual %0h", $time, name, want, got);
			return 1;
		end
		return 0;
	endfunction

	task automatic open_packet();
		crc_acc = 32'hFFFF_FFFF;
		for (int i = 0; i < 4; i++) begin
			tail[i] = 8'd0;
		end
		seen = 0;
		magic_good = 1'b1;
	endtask

	// Fold one accepted input beat into the packet state; the last byte yields a verdict.
	task automatic absorb_byte(input logic [7:0] b, input logic fin, input logic rerr);
		verdict_rec_t rec;
		logic [31:0]  trailer;
		if (seen < 4) begin
			if (b != magic_reg[8 * (3 - seen) +: 8]) begin
				magic_good = 1'b0;
			end
		end else begin
			crc_acc = crc_fold(crc_acc, tail[0]);
		end
		tail[0] = tail[1];
		tail[1] = tail[2];
		tail[2] = tail[3];
		tail[3] = b;
		if (seen <= MAX_BYTES) begin
			seen++;
		end
		if (fin) begin
			trailer = {tail[0], tail[1], tail[2], tail[3]};
			if (seen > MAX_BYTES) begin
				// Oversized packets leave every counter alone.
				rec.code = V_LONG;
			end else begin
				tally[CNT_TOTAL] += 1;
				if (rerr) begin
					rec.code = V_RADIO;
					tally[CNT_RADIO] += 1;
				end else if (seen < min_reg || seen < 4 || !magic_good) begin
					rec.code = V_MAGIC;
					tally[CNT_MAGIC] += 1;
				end else if (trailer != ~crc_acc) begin
					rec.code = V_CRC;
					tally[CNT_CRC] += 1;
				end else begin
					rec.code = V_FWD;
					tally[CNT_FWD] += 1;
					if (seen < size_split) begin
						tally[CNT_SMALL] += 1;
					end else begin
						tally[CNT_LARGE] += 1;
					end
				end
			end
			rec.len = (seen > 256) ? 9'd256 : 9'(seen);
			rec.cnt = tally;
			pending_verdicts.push_back(rec);
			open_packet();
		end
	endtask

	// Compare one accepted result beat with the oldest expected verdict.
	task automatic check_result();
		verdict_rec_t             want;
		logic [NUM_CNT-1:0][31:0] got;
		got[CNT_TOTAL] = total_count;
		got[CNT_FWD]   = forwarded_count;
		got[CNT_MAGIC] = magic_reject_count;
		got[CNT_CRC]   = crc_reject_count;
		got[CNT_RADIO] = radio_error_count;
		got[CNT_SMALL] = small_count;
		got[CNT_LARGE] = large_count;
		if (pending_verdicts.size() == 0) begin
			$display("%0t unexpected result beat: expected none, actual verdict %0d length %0d",
				$time, verdict, packet_length);
			fails++;
		end else begin
			want = pending_verdicts.pop_front();
			fails += field_diff("verdict", 32'(want.code), 32'(verdict));
			fails += field_diff("packet_length", 32'(want.len), 32'(packet_length));
			for (int k = 0; k < NUM_CNT; k++) begin
				fails += field_diff(slot_name[k], want.cnt[k], got[k]);
			end
		end
	endtask

	// Sample both channels and the register port at each rising edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			magic_reg = MAGIC_RESET;
			min_reg = MIN_RESET;
			size_split = SMALL_RESET;
			tally = '0;
			pending_verdicts.delete();
			open_packet();
		end else begin
			if (pop && !empty) begin
				check_result();
			end
			if (push && !full) begin
				absorb_byte(data_byte, last_byte, radio_error);
			end
			if (cfg_write) begin
				case (cfg_index)
					CFG_MAGIC: magic_reg = cfg_data;
					CFG_MIN: min_reg = cfg_data[7:0];
					CFG_SMALL: size_split = cfg_data[8:0];
					default: ;
				endcase
			end
		end
		depth = pending_verdicts.size();
	end

endmodule

// ===== test/packet_magic_crc32_validator_unit_test.sv =====
`timescale 1ns / 1ps

module packet_magic_crc32_validator_unit_test;
	import pmcv_pkg::*;

	typedef enum {PK_GOOD, PK_BAD_MAGIC, PK_BAD_CRC, PK_RADIO, PK_NOISE} pkt_kind_t;

	// Index past the register list; writes to it must be ignored.
	localparam logic [1:0] CFG_UNUSED = 2'd3;
	localparam logic [31:0] IEEE_REFLECTED = 32'hEDB8_8320;

	logic        clk;
	logic        arst_n;
	logic        cfg_write;
	logic [1:0]  cfg_index;
	logic [31:0] cfg_data;
	logic        push;
	logic        full;
	logic [7:0]  data_byte;
	logic        last_byte;
	logic        radio_error;
	logic        empty;
	logic        pop;
	logic [2:0]  verdict;
	logic [8:0]  packet_length;
	logic [31:0] total_count;
	logic [31:0] forwarded_count;
	logic [31:0] magic_reject_count;
	logic [31:0] crc_reject_count;
	logic [31:0] radio_error_count;
	logic [31:0] small_count;
	logic [31:0] large_count;
	int          mismatches;
	int          waiting;

	logic [31:0] cur_magic;
	int          cur_min;
	bit          tx_gaps = 1'b1;
	bit          rx_gaps = 1'b1;
	bit          stall_req = 1'b0;
	int          rx_hold;

	packet_magic_crc32_validator_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.push(push),
		.full(full),
		.data_byte(data_byte),
		.last_byte(last_byte),
		.radio_error(radio_error),
		.empty(empty),
		.pop(pop),
		.verdict(verdict),
		.packet_length(packet_length),
		.total_count(total_count),
		.forwarded_count(forwarded_count),
		.magic_reject_count(magic_reject_count),
		.crc_reject_count(crc_reject_count),
		.radio_error_count(radio_error_count),
		.small_count(small_count),
		.large_count(large_count)
	);

	packet_verdict_checker verdict_check (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.push(push),
		.full(full),
		.data_byte(data_byte),
		.last_byte(last_byte),
		.radio_error(radio_error),
		.empty(empty),
		.pop(pop),
		.verdict(verdict),
		.packet_length(packet_length),
		.total_count(total_count),
		.forwarded_count(forwarded_count),
		.magic_reject_count(magic_reject_count),
		.crc_reject_count(crc_reject_count),
		.radio_error_count(radio_error_count),
		.small_count(small_count),
		.large_count(large_count),
		.mismatches(mismatches),
		.waiting(waiting)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Hang guard, far above the slowest legal run.
	initial begin
		#2_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Mostly short gaps, some medium, a few long.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 80) begin
			return $urandom_range(1, 3);
		end else if (r < 97) begin
			return $urandom_range(4, 12);
		end
		return $urandom_range(20, 60);
	endfunction

	function automatic pkt_kind_t pick_kind();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) begin
			return PK_GOOD;
		end else if (r < 65) begin
			return PK_BAD_MAGIC;
		end else if (r < 80) begin
			return PK_BAD_CRC;
		end else if (r < 90) begin
			return PK_RADIO;
		end
		return PK_NOISE;
	endfunction

	// Trailer generator: reflected CRC-32 over the covered bytes.
	function automatic logic [31:0] crc_fold(input logic [31:0] acc, input logic [7:0] b);
		logic [31:0] r;
		r = acc ^ {24'd0, b};
		for (int i = 0; i < 8; i++) begin
			r = r[0] ? ((r >> 1) ^ IEEE_REFLECTED) : (r >> 1);
		end
		return r;
	endfunction

	// Offer one input beat and hold it until accepted; returns at a falling edge.
	task automatic send_beat(input logic [7:0] b, input logic fin, input logic rerr);
		if (tx_gaps && $urandom_range(0, 99) < 30) begin
			push <= 1'b0;
			repeat (pick_gap()) @(negedge clk);
		end
		push <= 1'b1;
		data_byte <= b;
		last_byte <= fin;
		radio_error <= rerr;
		do @(posedge clk); while (full);
		@(negedge clk);
	endtask

	// Build a packet of the given kind: magic head, random body, CRC trailer; noise is all random.
	task automatic send_packet(input int len, input pkt_kind_t kind);
		logic [7:0]  pkt [0:299];
		logic [31:0] acc;
		int          hit;
		for (int k = 0; k < len; k++) begin
			pkt[k] = 8'($urandom_range(0, 255));
		end
		if (kind != PK_NOISE) begin
			for (int k = 0; k < 4 && k < len; k++) begin
				pkt[k] = cur_magic[8 * (3 - k) +: 8];
			end
			if (len >= 4) begin
				acc = 32'hFFFF_FFFF;
				for (int k = 0; k < len - 4; k++) begin
					acc = crc_fold(acc, pkt[k]);
				end
				acc = ~acc;
				for (int k = 0; k < 4; k++) begin
					pkt[len - 4 + k] = acc[8 * (3 - k) +: 8];
				end
			end
		end
		// Single bit flips: one in the magic, or one past it to break the CRC.
		if (kind == PK_BAD_MAGIC) begin
			hit = $urandom_range(0, ((len < 4) ? len : 4) - 1);
			pkt[hit] = pkt[hit] ^ (8'd1 << $urandom_range(0, 7));
		end else if (kind == PK_BAD_CRC && len > 4) begin
			hit = $urandom_range(4, len - 1);
			pkt[hit] = pkt[hit] ^ (8'd1 << $urandom_range(0, 7));
		end
		// The radio flag only matters on the last byte; elsewhere it is noise.
		for (int k = 0; k < len; k++) begin
			if (k == len - 1) begin
				send_beat(pkt[k], 1'b1, kind == PK_RADIO);
			end else begin
				send_beat(pkt[k], 1'b0, 1'($urandom_range(0, 1)));
			end
		end
	endtask

	// Random packets until the byte budget is spent.
	task automatic run_packets(input int budget, input int lo, input int hi, input bit long_ok);
		int sent;
		int len;
		int r;
		sent = 0;
		while (sent < budget) begin
			r = $urandom_range(0, 99);
			if (long_ok && r < 2) begin
				len = $urandom_range(256, 270);
			end else if (r < 12) begin
				len = $urandom_range(1, (lo > 1) ? lo - 1 : 1);
			end else begin
				len = $urandom_range(lo, (hi > 255) ? 255 : hi);
			end
			send_packet(len, pick_kind());
			sent += len;
		end
	endtask

	// Register writes go out on consecutive cycles; close_regs drops the enable.
	task automatic program_reg(input logic [1:0] idx, input logic [31:0] value);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
	endtask

	task automatic close_regs();
		cfg_write <= 1'b0;
		@(negedge clk);
	endtask

	// Stop offering and wait until every verdict beat has been taken.
	task automatic drain();
		push <= 1'b0;
		while (waiting != 0) @(negedge clk);
		repeat (6) @(negedge clk);
	endtask

	// Result side: random hold-offs, plus one long stall on request.
	initial begin
		pop = 1'b0;
		rx_hold = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (stall_req) begin
				stall_req = 1'b0;
				rx_hold = 300;
			end
			if (rx_hold > 0) begin
				pop <= 1'b0;
				rx_hold--;
			end else begin
				pop <= 1'b1;
				if (rx_gaps && $urandom_range(0, 99) < 30) begin
					rx_hold = pick_gap();
				end
			end
		end
	end

	initial begin
		logic [31:0] word;
		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_index = CFG_MAGIC;
		cfg_data = 32'd0;
		push = 1'b0;
		data_byte = 8'd0;
		last_byte = 1'b0;
		radio_error = 1'b0;
		cur_magic = MAGIC_RESET;
		cur_min = MIN_RESET;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset defaults: a clean packet, a one-byte packet, a radio failure.
		send_packet(12, PK_GOOD);
		send_beat(8'h52, 1'b1, 1'b0);
		send_packet(12, PK_RADIO);
		run_packets(250, 12, 40, 1'b1);
		drain();

		// Upper extremes: all-ones magic, longest minimum, size split past the maximum.
		cur_magic = 32'hFFFF_FFFF;
		cur_min = 255;
		program_reg(CFG_MAGIC, cur_magic);
		program_reg(CFG_MIN, 32'd255);
		program_reg(CFG_SMALL, 32'd256);
		close_regs();
		send_packet(255, PK_GOOD);
		send_packet(255, PK_BAD_CRC);
		send_packet(256, PK_GOOD);
		repeat (8) send_packet($urandom_range(4, 20), pick_kind());
		drain();

		// Zero magic, minimum below its range, zero split; junk above the register widths.
		// The receiver stalls here while tiny packets keep coming, so the input backs up.
		cur_magic = 32'd0;
		cur_min = 0;
		program_reg(CFG_MAGIC, cur_magic);
		program_reg(CFG_MIN, 32'hABCD_EF00);
		program_reg(CFG_SMALL, 32'h5A5A_5E00);
		close_regs();
		tx_gaps = 1'b0;
		stall_req = 1'b1;
		send_packet(4, PK_GOOD);
		send_packet(2, PK_GOOD);
		send_packet(3, PK_GOOD);
		run_packets(250, 1, 8, 1'b0);
		drain();
		tx_gaps = 1'b1;

		// Random magic and minimum, everything small; no idling on either side.
		cur_magic = $urandom;
		cur_min = $urandom_range(8, 40);
		word = $urandom;
		program_reg(CFG_MAGIC, cur_magic);
		program_reg(CFG_MIN, {word[31:8], 8'(cur_min)});
		program_reg(CFG_SMALL, {word[22:0], 9'h1FF});
		program_reg(CFG_UNUSED, $urandom);
		close_regs();
		tx_gaps = 1'b0;
		rx_gaps = 1'b0;
		run_packets(250, cur_min, cur_min + 30, 1'b1);
		drain();
		tx_gaps = 1'b1;
		rx_gaps = 1'b1;

		// Lowest legal minimum with a random size split.
		cur_magic = $urandom;
		cur_min = 8;
		program_reg(CFG_MAGIC, cur_magic);
		program_reg(CFG_MIN, 32'd8);
		program_reg(CFG_SMALL, 32'($urandom_range(0, 256)));
		close_regs();
		run_packets(250, 8, 60, 1'b1);
		drain();

		repeat (10) @(negedge clk);
		if (mismatches == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
